### src/iir_direct_form_one_filter_unit_macros.svh
// Assertion macros used by the port-level checker of the direct form I IIR filter.
`ifndef IIR_DIRECT_FORM_ONE_FILTER_UNIT_MACROS_SVH
`define IIR_DIRECT_FORM_ONE_FILTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define IIRDF1_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define IIRDF1_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/iirdf1_pkg.sv
// Types, constants and register codes of the direct form I IIR filter.
package iirdf1_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int FF_TAPS    = 4;
    localparam int FB_TAPS    = 4;
    // One cell per feedforward tap; the feedback chain holds y[n-2] .. y[n-4].
    localparam int X_CELLS    = 4;
    localparam int Y_CELLS    = 3;
    localparam int NUM_REGS   = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_SEL_W  = $clog2(NUM_REGS);
    localparam int ACC_W      = PROD_W + 4;
    localparam int FRAC_SHIFT = 14;
    localparam int RND_W      = ACC_W - FRAC_SHIFT;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [PROD_W-1:0]   product_t;
    typedef logic signed [ACC_W-1:0]    acc_t;
    typedef logic signed [RND_W-1:0]    rnd_t;

    localparam acc_t    ROUND_HALF = acc_t'(1 << (FRAC_SHIFT - 1));
    localparam rnd_t    RND_HI     = rnd_t'(32767);
    localparam rnd_t    RND_LO     = -rnd_t'(32768);
    localparam sample_t SAT_HI     = 16'sh7fff;
    localparam sample_t SAT_LO     = 16'sh8000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_B0 = 4'd0,
        REG_B1 = 4'd1,
        REG_B2 = 4'd2,
        REG_B3 = 4'd3,
        REG_A1 = 4'd4,
        REG_A2 = 4'd5,
        REG_A3 = 4'd6,
        REG_A4 = 4'd7
    } cfg_reg_t;

    // Control of one tap cell: shift the held sample, load the product,
    // and multiply the incoming sample instead of the held one.
    typedef struct packed {
        logic shift;
        logic load;
        logic use_in;
    } cell_ctrl_t;

endpackage

### src/iirdf1_tap_cell.sv
// One tap cell: a delay-line register and a registered coefficient product.
module iirdf1_tap_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  iirdf1_pkg::cell_ctrl_t ctrl,
    input  iirdf1_pkg::sample_t  shift_in,
    input  iirdf1_pkg::coef_t    coef,
    output iirdf1_pkg::sample_t  held,
    output iirdf1_pkg::product_t product
);
    import iirdf1_pkg::*;

    sample_t  held_reg;
    sample_t  operand;
    product_t product_reg;
    product_t product_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
        end else if (ctrl.shift) begin
            held_reg <= shift_in;
        end
    end

    always_comb begin
        operand      = ctrl.use_in ? shift_in : held_reg;
        product_next = product_t'(coef) * product_t'(operand);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            product_reg <= product_next;
        end
    end

    assign held    = held_reg;
    assign product = product_reg;

endmodule

### src/iirdf1_acc.sv
// Final stage: sums the tap products with the y[n-1] feedback, rounds and saturates.
module iirdf1_acc (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  iirdf1_pkg::product_t ff_prod [iirdf1_pkg::X_CELLS],
    input  iirdf1_pkg::product_t fb_prod [iirdf1_pkg::Y_CELLS],
    input  iirdf1_pkg::coef_t    coef_a1,
    input  logic                 stage_valid,
    input  logic                 m_tready,
    output logic                 fire,
    output iirdf1_pkg::sample_t  y_last,
    output logic                 m_tvalid,
    output iirdf1_pkg::sample_t  m_tdata,
    output logic                 m_tuser
);
    import iirdf1_pkg::*;

    sample_t y1_reg;
    logic    valid_reg;
    logic    valid_next;
    sample_t data_reg;
    logic    clip_reg;
    acc_t    sum;
    rnd_t    rounded;
    sample_t y_next;
    logic    clip_next;

    // The y[n-1] product sits in this loop, so it is formed here and not in a cell.
    always_comb begin
        sum = acc_t'(coef_a1) * acc_t'(y1_reg) + ROUND_HALF;
        for (int k = 0; k < X_CELLS; k++) begin
            sum = sum + acc_t'(ff_prod[k]);
        end
        for (int k = 0; k < Y_CELLS; k++) begin
            sum = sum + acc_t'(fb_prod[k]);
        end
        rounded = sum[ACC_W-1:FRAC_SHIFT];
        if (rounded > RND_HI) begin
            y_next    = SAT_HI;
            clip_next = 1'b1;
        end else if (rounded < RND_LO) begin
            y_next    = SAT_LO;
            clip_next = 1'b1;
        end else begin
            y_next    = rounded[SAMPLE_W-1:0];
            clip_next = 1'b0;
        end
    end

    assign fire = stage_valid && (!valid_reg || m_tready);

    always_comb begin
        if (fire) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            y1_reg    <= '0;
        end else begin
            valid_reg <= valid_next;
            if (fire) begin
                y1_reg <= y_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            data_reg <= y_next;
            clip_reg <= clip_next;
        end
    end

    assign y_last   = y1_reg;
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = clip_reg;

endmodule

### src/iir_direct_form_one_filter_unit.sv
// Direct form I IIR filter top level: coefficient registers, tap cell chains, output stage.
//
//  channel  direction  handshake            payload
//  s_       in         s_tvalid / s_tready  s_tdata = sample_in
//  m_       out        m_tvalid / m_tready  m_tdata = sample_out, m_tuser = clipped
//  cfg_     in         cfg_valid / cfg_ready cfg_index, cfg_data = coefficient
//
// Throughput is one sample per cycle while the output is not stalled; m_tvalid rises once an
// accepted sample has passed the product stage register and then the output register.
// The rate is set by the y[n-1] loop in iirdf1_acc: multiply, sum, round and saturate.
// Reset clears the coefficients, both delay lines and the output valid flag.
// While a result waits on m_tready, one more sample is taken into the product stage.
module iir_direct_form_one_filter_unit (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // [15:0] sample_in
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // [15:0] sample_out
    output logic                  m_tuser,   // [0] clipped
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [3:0]            cfg_index,
    input  logic [15:0]           cfg_data
);
    import iirdf1_pkg::*;

    coef_t      coef_reg  [NUM_REGS];
    coef_t      coef_next [NUM_REGS];
    logic       stage_valid_reg;
    logic       accept;
    logic       fire;
    cell_ctrl_t x_ctrl;
    cell_ctrl_t y_ctrl;
    sample_t    x_link [X_CELLS];
    sample_t    y_link [Y_CELLS];
    product_t   ff_prod [X_CELLS];
    product_t   fb_prod [Y_CELLS];
    coef_t      coef_a1;
    sample_t    y_last;
    sample_t    out_data;

    // Coefficient registers.
    always_comb begin
        coef_next = coef_reg;
        if (cfg_valid) begin
            unique case (cfg_index) inside
                [REG_B0:REG_A4]: coef_next[cfg_index[CFG_SEL_W-1:0]] = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                coef_reg[i] <= '0;
            end
        end else begin
            coef_reg <= coef_next;
        end
    end

    assign cfg_ready = 1'b1;

    // Product stage occupancy.
    assign s_tready = !stage_valid_reg || fire;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else if (accept) begin
            stage_valid_reg <= 1'b1;
        end else if (fire) begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_comb begin
        x_ctrl.shift  = accept;
        x_ctrl.load   = accept;
        x_ctrl.use_in = 1'b1;
        // While the previous sample is still in the product stage, y[n-1] is not yet in
        // the feedback line, so each cell multiplies what its neighbor hands it.
        y_ctrl.shift  = fire;
        y_ctrl.load   = accept;
        y_ctrl.use_in = stage_valid_reg;
    end

    assign x_link[0] = s_tdata;
    assign y_link[0] = y_last;

    for (genvar k = 0; k < X_CELLS; k++) begin : g_x
        coef_t b_coef;
        assign b_coef = (k < FF_TAPS) ? coef_reg[int'(REG_B0) + k] : '0;
        if (k < X_CELLS - 1) begin : g_link
            iirdf1_tap_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctrl     (x_ctrl),
                .shift_in (x_link[k]),
                .coef     (b_coef),
                .held     (x_link[k+1]),
                .product  (ff_prod[k])
            );
        end else begin : g_end
            iirdf1_tap_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctrl     (x_ctrl),
                .shift_in (x_link[k]),
                .coef     (b_coef),
                .held     (),
                .product  (ff_prod[k])
            );
        end
    end

    for (genvar c = 0; c < Y_CELLS; c++) begin : g_y
        coef_t a_coef;
        assign a_coef = (c + 2 <= FB_TAPS) ? coef_reg[int'(REG_A2) + c] : '0;
        if (c < Y_CELLS - 1) begin : g_link
            iirdf1_tap_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctrl     (y_ctrl),
                .shift_in (y_link[c]),
                .coef     (a_coef),
                .held     (y_link[c+1]),
                .product  (fb_prod[c])
            );
        end else begin : g_end
            iirdf1_tap_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctrl     (y_ctrl),
                .shift_in (y_link[c]),
                .coef     (a_coef),
                .held     (),
                .product  (fb_prod[c])
            );
        end
    end

    assign coef_a1 = (FB_TAPS >= 1) ? coef_reg[int'(REG_A1)] : '0;

    iirdf1_acc u_acc (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ff_prod     (ff_prod),
        .fb_prod     (fb_prod),
        .coef_a1     (coef_a1),
        .stage_valid (stage_valid_reg),
        .m_tready    (m_tready),
        .fire        (fire),
        .y_last      (y_last),
        .m_tvalid    (m_tvalid),
        .m_tdata     (out_data),
        .m_tuser     (m_tuser)
    );

    assign m_tdata = out_data;

endmodule

### src/iirdf1_checker.sv
// Port-level checker for the direct form I IIR filter, bound to the top level.
`include "iir_direct_form_one_filter_unit_macros.svh"

module iirdf1_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser
);

    // A clipped result always sits at one of the two rails.
    `IIRDF1_ASSERT_IMPLY(a_clip_rail, aclk, aresetn, m_tvalid && m_tuser, (m_tdata == 16'h7fff || m_tdata == 16'h8000), "clipped result is not at a rail")

    // Input back-pressure only comes from a stalled result.
    `IIRDF1_ASSERT_IMPLY(a_stall_source, aclk, aresetn, !s_tready, m_tvalid && !m_tready, "input stalled without a stalled output")

    // No result in the first cycle after reset.
    `IIRDF1_ASSERT_IMPLY(a_reset_empty, aclk, aresetn, $past(!aresetn), !m_tvalid, "result valid right after reset")

    // A result that is not taken holds its value.
    `IIRDF1_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind iir_direct_form_one_filter_unit iirdf1_checker u_iirdf1_checker (.*);
